// ===== hw/rtl/lru_key_value_cache_top_defines.svh =====
// Assertion macros shared by the LRU key/value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkvc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkvc: next-cycle check failed");

`endif

// ===== hw/rtl/lkvc_pkg.sv =====
// Package with the shared constants and types of the LRU key/value cache.
`timescale 1ns / 1ps
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried by the mode field.
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Decision of the tag array for one lookup.
    typedef struct packed {
        logic hit;
        logic ram_we;
        logic ram_re;
    } t_lkvc_act;

endpackage

// ===== hw/rtl/lkvc_value_ram.sv =====
// Single-port value memory with a registered read port.
`timescale 1ns / 1ps
module lkvc_value_ram
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int SW      = $clog2(ENTRIES)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [SW-1:0]    i_addr,
    input  logic [VAL_W-1:0] i_wdata,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [ENTRIES];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lkvc_tag_array.sv =====
// Key tags, valid bits, recency ranks and occupancy with the replacement decision.
`timescale 1ns / 1ps
`include "lru_key_value_cache_top_defines.svh"
module lkvc_tag_array
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int SW      = $clog2(ENTRIES),
    parameter int CW      = $clog2(ENTRIES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CAP_W-1:0] i_cap,
    input  logic             i_lookup,
    input  logic             i_mode,
    input  logic [KEY_W-1:0] i_key,
    output t_lkvc_act        o_act,
    output logic [SW-1:0]    o_slot
);

    localparam int MW = (CW > CAP_W) ? CW : CAP_W;

    logic [ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0]   r_key [ENTRIES];
    logic [SW-1:0]      r_rank [ENTRIES];
    logic [CW-1:0]      r_occ;

    logic [ENTRIES-1:0] n_valid;
    logic [SW-1:0]      n_rank [ENTRIES];
    logic [CW-1:0]      n_occ;

    logic               found;
    logic [SW-1:0]      hit_slot;
    logic [SW-1:0]      hit_rank;
    logic [MW-1:0]      cap_ext;
    logic [MW-1:0]      eff_cap;
    logic               evict;
    logic [CW-1:0]      occ_m1;
    logic [SW-1:0]      last_rank;
    logic               got;
    logic [SW-1:0]      victim_slot;
    logic [ENTRIES-1:0] valid_after;
    logic               free_found;
    logic [SW-1:0]      free_slot;
    logic               insert;
    logic               drop;

    always_comb begin
        found    = 1'b0;
        hit_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key[i] == i_key)) begin
                found    = 1'b1;
                hit_slot = SW'(i);
            end
        end
        hit_rank = r_rank[hit_slot];

        // Capacity zero acts as one; capacity above the store saturates.
        cap_ext = MW'(i_cap);
        eff_cap = cap_ext;
        if (cap_ext == '0) begin
            eff_cap = MW'(1);
        end else if (cap_ext > MW'(ENTRIES)) begin
            eff_cap = MW'(ENTRIES);
        end

        evict = (i_mode == MODE_PUT) && !found && (r_occ != '0)
                && (MW'(r_occ) >= eff_cap);

        occ_m1    = r_occ - CW'(1);
        last_rank = occ_m1[SW-1:0];
        got         = 1'b0;
        victim_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_rank[i] == last_rank)) begin
                got         = 1'b1;
                victim_slot = SW'(i);
            end
        end
        drop = evict && got;

        valid_after = r_valid;
        if (drop) begin
            valid_after[victim_slot] = 1'b0;
        end

        free_found = 1'b0;
        free_slot  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_after[i]) begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end

        insert = (i_mode == MODE_PUT) && !found && free_found;

        o_act.hit    = found;
        o_act.ram_we = ((i_mode == MODE_PUT) && found) || insert;
        o_act.ram_re = (i_mode == MODE_GET) && found;
        o_slot       = found ? hit_slot : free_slot;

        // Recency update: a hit ages the entries newer than it, an insert ages all remaining valid ones.
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (found) begin
                if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                    n_rank[i] = r_rank[i] + SW'(1);
                end
                if (SW'(i) == hit_slot) begin
                    n_rank[i] = '0;
                end
            end else begin
                if (drop && (SW'(i) == victim_slot)) begin
                    n_rank[i] = '0;
                end
                if (insert) begin
                    if (valid_after[i]) begin
                        n_rank[i] = r_rank[i] + SW'(1);
                    end
                    if (SW'(i) == free_slot) begin
                        n_rank[i] = '0;
                    end
                end
            end
        end

        n_valid = valid_after;
        if (insert) begin
            n_valid[free_slot] = 1'b1;
        end
        n_occ = r_occ - CW'(drop) + CW'(insert);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_lookup) begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lookup && insert) begin
            r_key[free_slot] <= i_key;
        end
    end

    `LKVC_ASSERT_IMPL(a_occ_matches_valid, i_clk, i_rst_n, 1'b1, $countones(r_valid) == r_occ)
    `LKVC_ASSERT_IMPL(a_occ_bounded, i_clk, i_rst_n, 1'b1, r_occ <= CW'(ENTRIES))
    `LKVC_ASSERT_IMPL(a_one_ram_op, i_clk, i_rst_n, i_lookup, !(o_act.ram_we && o_act.ram_re))

endmodule

// ===== hw/rtl/lru_key_value_cache_top.sv =====
// Top level of the fully associative LRU key/value cache.
`timescale 1ns / 1ps
`include "lru_key_value_cache_top_defines.svh"
// The block holds up to ENTRIES key/value pairs and serves one get or put per
// input transfer, returning exactly one result transfer for each. Keys, valid
// bits and recency ranks live in registers so that all keys are compared in
// parallel; values live in a single-port synchronous memory. Each item passes
// through these steps in order: its capture into the item registers in the
// idle state, the lookup state in which the tag array compares the key, picks
// the slot, updates recency and issues the memory access, and the done state
// in which the registered memory read data is moved into the output register
// once that register is free. No new item is taken until the previous one has
// left the done state, but a new item can be taken while the previous result
// still waits in the output register. The cache is empty after reset and needs
// no clearing pass. The capacity register may be written at any time the block
// is idle; zero acts as one and values above ENTRIES act as ENTRIES. Lowering
// the capacity below the occupancy drops nothing at once; each later insertion
// then evicts one entry.
module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CAP_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_mode,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic signed [VAL_W-1:0] i_write_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_hit,
    output logic signed [VAL_W-1:0] o_read_value
);

    localparam int SW = $clog2(ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [CAP_W-1:0] r_cap;
    logic             r_mode;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_wval;
    logic             r_hit;
    logic             r_get_hit;
    logic             r_out_valid;
    logic             r_out_hit;
    logic [VAL_W-1:0] r_out_value;

    t_lkvc_act        act;
    logic [SW-1:0]    slot;
    logic [VAL_W-1:0] ram_rdata;
    logic             lookup;
    logic             out_free;

    assign lookup      = (r_state == S_LOOK);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    lkvc_tag_array #(
        .ENTRIES (ENTRIES)
    ) u_tags (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cap    (r_cap),
        .i_lookup (lookup),
        .i_mode   (r_mode),
        .i_key    (r_key),
        .o_act    (act),
        .o_slot   (slot)
    );

    lkvc_value_ram #(
        .ENTRIES (ENTRIES)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (lookup && act.ram_we),
        .i_re    (lookup && act.ram_re),
        .i_addr  (slot),
        .i_wdata (r_wval),
        .o_rdata (ram_rdata)
    );

    // Item capture and result handling. The item is held from its transfer
    // until the tag array has acted on it; the result then waits in S_DONE
    // until the output register is free. In S_DONE the output register is
    // either reloaded or left waiting, so it is only emptied in other states.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode  <= i_mode;
                        r_key   <= i_key;
                        r_wval  <= i_write_value;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_hit     <= act.hit;
                    r_get_hit <= act.ram_re;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_hit;
                        r_out_value <= r_get_hit ? ram_rdata : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_value;

    `LKVC_ASSERT_NEXT(a_accept_to_look, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_LOOK)
    `LKVC_ASSERT_NEXT(a_done_emits, i_clk, i_rst_n, (r_state == S_DONE) && out_free, o_out_valid && (r_state == S_IDLE))
    `LKVC_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_hit, o_read_value == '0)

endmodule
